// ===== src/strsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package strsm_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = IDX_W + 1;
  localparam int ST_W   = 2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SECOND = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD       = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } pair_t;

  // Equal minima collapse into one element.
  function automatic pair_t pair_merge(input pair_t x, input pair_t y);
    pair_t m;
    if (x.lo == y.lo) begin
      m.lo = x.lo;
      m.hi = (x.hi < y.hi) ? x.hi : y.hi;
    end else if (x.lo < y.lo) begin
      m.lo = x.lo;
      m.hi = (x.hi < y.lo) ? x.hi : y.lo;
    end else begin
      m.lo = y.lo;
      m.hi = (y.hi < x.lo) ? y.hi : x.lo;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/sparse_table_range_second_min_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Range second-smallest query engine. Values are appended into level 0 of a
// sparse table of (smallest, second smallest) pairs held in one synchronous
// memory of LEVELS x 2^ceil(log2(MAX_ELEMENTS)) entries, with one write port
// and two read ports. A build request fills levels 1..LEVELS-1 by merging
// pairs of the level below, one merge per cycle; a query reads the two
// covering blocks of its level and merges the registered read data in
// S_QMRG, reporting once the result slot is free. A build is paced by the
// single merge unit walking the table memory, with a drain state between
// levels so a level never reads an entry of the level below before it is
// written. No clearing pass: table contents are only read after they
// were written. Equal values collapse into one element, so the block
// assumes distinct values; a one-element range reports 2147483647 with
// status "no second".
module sparse_table_range_second_min_core
  import strsm_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11
) (
  input  wire                     clk,
  input  wire                     rst_n,

  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [CMD_W-1:0]        in_cmd,
  input  wire  signed [DATA_W-1:0] in_value,
  input  wire  [IDX_W-1:0]        in_left_index,
  input  wire  [IDX_W-1:0]        in_right_index,

  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [DATA_W-1:0] out_second_min,
  output logic [ST_W-1:0]         out_status
);

  // ---------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------
  localparam int IW    = $clog2(MAX_ELEMENTS);       // entry index within a level
  localparam int LW    = $clog2(LEVELS);             // level field of the address
  localparam int AW    = LW + IW;
  localparam int DEPTH = LEVELS << IW;
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);   // element count
  localparam int KW    = $clog2(LEVELS + 1);         // build level counter
  localparam int WA    = (CW > LEVELS) ? CW : LEVELS;
  localparam int WW    = ((WA > LEN_W) ? WA : LEN_W) + 1;  // compare width
  localparam int QKW   = $clog2(LEN_W);              // query level

  // ---------------------------------------------------------------------
  // Sequencer states
  // ---------------------------------------------------------------------
  localparam logic [2:0] S_IDLE  = 3'd0;  // take a request
  localparam logic [2:0] S_QMRG  = 3'd1;  // query data back, merge, report
  localparam logic [2:0] S_BLVL  = 3'd2;  // start a build level or finish
  localparam logic [2:0] S_BRD   = 3'd3;  // issue one merge read per cycle
  localparam logic [2:0] S_BDRN  = 3'd4;  // last write of the level lands
  localparam logic [2:0] S_BDONE = 3'd5;  // report the build

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          built_r, built_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] wi_r, wi_nxt;         // index of the merge in flight
  logic          wr_pend_r, wr_pend_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_min_r, out_min_nxt;
  logic [ST_W-1:0]          out_status_r, out_status_nxt;

  // ---------------------------------------------------------------------
  // Pair table memory: 1 write, 2 reads, registered read data
  // ---------------------------------------------------------------------
  pair_t         mem [DEPTH];
  pair_t         rda_r, rdb_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  pair_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rda_r <= mem[rd_addr_a];
      rdb_r <= mem[rd_addr_b];
    end
  end

  pair_t merged;
  assign merged = pair_merge(rda_r, rdb_r);

  // ---------------------------------------------------------------------
  // Handshake: requests are taken only when idle and the result slot frees
  // ---------------------------------------------------------------------
  logic out_free, accept;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_second_min = out_min_r;
  assign out_status     = out_status_r;

  // ---------------------------------------------------------------------
  // Query decode straight off the input ports
  // ---------------------------------------------------------------------
  logic [LEN_W-1:0] q_len;
  logic [QKW-1:0]   q_k;
  logic [WW-1:0]    q_right_w, q_left_w, cnt_w, q_idx_b;
  logic             q_bad, q_one, full;

  always_comb begin
    q_len = LEN_W'(in_right_index) - LEN_W'(in_left_index) + LEN_W'(1);
    q_k   = '0;
    for (int j = 0; j < LEN_W; j++) begin
      if (q_len[j]) begin
        q_k = QKW'(j);
      end
    end
    q_right_w = WW'(in_right_index);
    q_left_w  = WW'(in_left_index);
    cnt_w     = WW'(cnt_r);
    q_bad     = !built_r || (in_left_index > in_right_index) || (q_right_w >= cnt_w) ||
                (32'(q_k) >= 32'(LEVELS));
    q_one     = (q_len == LEN_W'(1));
    q_idx_b   = q_right_w + WW'(1) - (WW'(1) << q_k);
    full      = (cnt_r >= CW'(MAX_ELEMENTS));
  end

  // ---------------------------------------------------------------------
  // Build walk: level k_r entry i_r merges level k_r-1 entries i and i+half
  // ---------------------------------------------------------------------
  logic [WW-1:0] b_size, b_half, b_i_w, b_idx_b;
  logic [LW-1:0] b_lvl_src;
  logic          b_last, b_lvl_end;

  always_comb begin
    b_size    = WW'(1) << k_r;
    b_half    = WW'(1) << (k_r - KW'(1));
    b_i_w     = WW'(i_r);
    b_idx_b   = b_i_w + b_half;
    b_lvl_src = LW'(k_r - KW'(1));
    b_last    = ((b_i_w + b_size) == cnt_w);
    b_lvl_end = (k_r == KW'(LEVELS)) || (b_size > cnt_w);
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    built_nxt      = built_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    wi_nxt         = wi_r;
    wr_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr_a      = {b_lvl_src, i_r};
    rd_addr_b      = {b_lvl_src, b_idx_b[IW-1:0]};
    wr_en          = 1'b0;
    wr_addr        = {LW'(k_r), wi_r};
    wr_data        = merged;

    // merge result of the previous build read
    if (wr_pend_r) begin
      wr_en = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_CLEAR: begin
              cnt_nxt        = '0;
              built_nxt      = 1'b0;
              out_valid_nxt  = 1'b1;
              out_min_nxt    = INT_MAX;
              out_status_nxt = ST_OK;
            end
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              out_min_nxt   = INT_MAX;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = {LW'(0), cnt_r[IW-1:0]};
                wr_data.lo     = in_value;
                wr_data.hi     = INT_MAX;
                cnt_nxt        = cnt_r + CW'(1);
                built_nxt      = 1'b0;
                out_status_nxt = ST_OK;
              end
            end
            CMD_BUILD: begin
              k_nxt     = KW'(1);
              state_nxt = S_BLVL;
            end
            CMD_QUERY: begin
              if (q_bad || q_one) begin
                out_valid_nxt  = 1'b1;
                out_min_nxt    = INT_MAX;
                out_status_nxt = q_bad ? ST_BAD : ST_NO_SECOND;
              end else begin
                rd_en     = 1'b1;
                rd_addr_a = {LW'(q_k), q_left_w[IW-1:0]};
                rd_addr_b = {LW'(q_k), q_idx_b[IW-1:0]};
                state_nxt = S_QMRG;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_QMRG: begin
        // read data holds until the slot frees
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_min_nxt    = merged.hi;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_BLVL: begin
        if (b_lvl_end) begin
          state_nxt = S_BDONE;
        end else begin
          i_nxt     = '0;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        rd_en       = 1'b1;
        wr_pend_nxt = 1'b1;
        wi_nxt      = i_r;
        if (b_last) begin
          state_nxt = S_BDRN;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_BDRN: begin
        k_nxt     = k_r + KW'(1);
        state_nxt = S_BLVL;
      end
      S_BDONE: begin
        if (out_free) begin
          built_nxt      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_min_nxt    = INT_MAX;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      built_r     <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      built_r     <= built_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wi_r         <= wi_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("request taken while busy");

  a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_BRD || state_r == S_BDRN))
    else $error("merge write outside a build level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BRD) |-> (k_r != '0 && k_r < KW'(LEVELS)))
    else $error("build level out of range");

  a_drain_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BDRN) |=> (state_r == S_BLVL && !wr_pend_r))
    else $error("level drain did not complete");

endmodule

`default_nettype wire
